### sv/csv_fe_pkg.sv
package csv_fe_pkg;

    // Default sizes of the block
    localparam int FIELD_BUF_BYTES_DEF = 512;
    localparam int MAX_FIELDS_DEF      = 32;

    // Register and field widths
    localparam int FIELD_INDEX_W = 5;
    localparam int MAX_LEN_W     = 9;
    localparam int MAX_LEN_RESET = 511;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd1;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] field_byte;
        logic       byte_valid;
        logic       line_done;
        logic       field_found;
    } out_item_t;

    typedef struct packed {
        logic [FIELD_INDEX_W-1:0] field_index;
        logic [MAX_LEN_W-1:0]     max_len;
    } cfg_t;

    // Parser modes, one-hot
    typedef enum logic [7:0] {
        MODE_START   = 8'b0000_0001,
        MODE_SKIP_P  = 8'b0000_0010,
        MODE_SKIP_Q  = 8'b0000_0100,
        MODE_SKIP_QQ = 8'b0000_1000,
        MODE_TAKE_P  = 8'b0001_0000,
        MODE_TAKE_Q  = 8'b0010_0000,
        MODE_TAKE_QQ = 8'b0100_0000,
        MODE_IDLE    = 8'b1000_0000
    } mode_t;

endpackage

### sv/csv_fe_in_reg.sv
module csv_fe_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  csv_fe_pkg::in_item_t in_item,
    input  logic                 advance,
    output logic                 s1_valid,
    output csv_fe_pkg::in_item_t s1_item
);

    logic                 valid_reg;
    logic                 valid_next;
    csv_fe_pkg::in_item_t item_reg;
    logic                 load;

    // Register may take a new item when empty or when its item moves on
    assign load       = in_valid && (!valid_reg || advance);
    assign in_stall   = valid_reg && !advance;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

### sv/csv_fe_parser.sv
module csv_fe_parser #(
    parameter int FIELD_BUF_BYTES = csv_fe_pkg::FIELD_BUF_BYTES_DEF,
    parameter int MAX_FIELDS      = csv_fe_pkg::MAX_FIELDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  csv_fe_pkg::cfg_t      cfg,
    input  csv_fe_pkg::in_item_t  s1_item,
    input  logic                  advance,
    output logic                  has_result,
    output csv_fe_pkg::out_item_t result
);

    localparam int LEN_W = $clog2(FIELD_BUF_BYTES);
    localparam int CNT_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int LIM_W = (LEN_W > csv_fe_pkg::MAX_LEN_W) ? LEN_W : csv_fe_pkg::MAX_LEN_W;
    localparam int CMP_W = (CNT_W > csv_fe_pkg::FIELD_INDEX_W) ? CNT_W
                                                               : csv_fe_pkg::FIELD_INDEX_W;
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_FIELDS - 1);
    localparam logic [LIM_W-1:0] LEN_CAP = LIM_W'(FIELD_BUF_BYTES - 1);

    csv_fe_pkg::mode_t mode_reg, mode_next, mode_cur;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_cur, cnt_bump, bf_cnt, bf_cnt_bump;
    logic [LEN_W-1:0]  len_reg, len_next, len_cur;
    logic              tgt_reg, tgt_next, tgt_cur;
    logic              open_reg, open_next;

    logic [7:0]        b;
    logic              ender, printable, is_quote, is_comma;
    logic [LIM_W-1:0]  limit, max_len_ext;
    logic              at_limit;
    logic              bf_hit;
    logic              emit;

    // Fresh line: per-line state is reloaded at its first byte
    assign mode_cur = open_reg ? mode_reg : csv_fe_pkg::MODE_START;
    assign cnt_cur  = open_reg ? cnt_reg : '0;
    assign len_cur  = open_reg ? len_reg : '0;
    assign tgt_cur  = open_reg ? tgt_reg : (cfg.field_index == '0);

    assign b         = s1_item.line_byte;
    assign ender     = (b == csv_fe_pkg::CH_NUL) || (b == csv_fe_pkg::CH_LF)
                       || (b == csv_fe_pkg::CH_CR);
    assign printable = (b >= csv_fe_pkg::CH_SPACE);
    assign is_quote  = (b == csv_fe_pkg::CH_QUOTE);
    assign is_comma  = (b == csv_fe_pkg::CH_COMMA);

    assign max_len_ext = LIM_W'(cfg.max_len);
    assign limit       = (max_len_ext < LEN_CAP) ? max_len_ext : LEN_CAP;
    assign at_limit    = (LIM_W'(len_cur) >= limit);

    assign cnt_bump    = (cnt_cur == CNT_TOP) ? cnt_cur : cnt_cur + 1'b1;
    // After a closing quote in a skipped field the new field starts one later
    assign bf_cnt      = (mode_cur == csv_fe_pkg::MODE_SKIP_QQ) ? cnt_bump : cnt_cur;
    assign bf_cnt_bump = (bf_cnt == CNT_TOP) ? bf_cnt : bf_cnt + 1'b1;
    assign bf_hit      = (CMP_W'(bf_cnt) == CMP_W'(cfg.field_index));

    always_comb
    begin
        mode_next = mode_cur;
        cnt_next  = cnt_cur;
        tgt_next  = tgt_cur;
        emit      = 1'b0;
        case (mode_cur)
            csv_fe_pkg::MODE_START,
            csv_fe_pkg::MODE_SKIP_QQ:
            begin
                if (mode_cur == csv_fe_pkg::MODE_SKIP_QQ && is_quote)
                begin
                    mode_next = csv_fe_pkg::MODE_SKIP_Q;
                end
                else if (mode_cur == csv_fe_pkg::MODE_SKIP_QQ && is_comma)
                begin
                    cnt_next  = cnt_bump;
                    mode_next = csv_fe_pkg::MODE_START;
                end
                else if (ender)
                begin
                    mode_next = csv_fe_pkg::MODE_IDLE;
                end
                else
                begin
                    // field start
                    cnt_next = bf_cnt;
                    if (bf_hit)
                    begin
                        tgt_next = 1'b1;
                        if (is_quote)
                        begin
                            mode_next = csv_fe_pkg::MODE_TAKE_Q;
                        end
                        else if (is_comma || at_limit)
                        begin
                            mode_next = csv_fe_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            mode_next = csv_fe_pkg::MODE_TAKE_P;
                            emit      = printable;
                        end
                    end
                    else if (is_quote)
                    begin
                        mode_next = csv_fe_pkg::MODE_SKIP_Q;
                    end
                    else if (is_comma)
                    begin
                        cnt_next  = bf_cnt_bump;
                        mode_next = csv_fe_pkg::MODE_START;
                    end
                    else
                    begin
                        mode_next = csv_fe_pkg::MODE_SKIP_P;
                    end
                end
            end
            csv_fe_pkg::MODE_SKIP_P:
            begin
                if (is_comma)
                begin
                    cnt_next  = cnt_bump;
                    mode_next = csv_fe_pkg::MODE_START;
                end
                else if (ender)
                begin
                    mode_next = csv_fe_pkg::MODE_IDLE;
                end
            end
            csv_fe_pkg::MODE_SKIP_Q:
            begin
                // CR and LF belong to a skipped quoted field
                if (is_quote)
                begin
                    mode_next = csv_fe_pkg::MODE_SKIP_QQ;
                end
                else if (b == csv_fe_pkg::CH_NUL)
                begin
                    mode_next = csv_fe_pkg::MODE_IDLE;
                end
            end
            csv_fe_pkg::MODE_TAKE_P:
            begin
                if (ender || is_comma || at_limit)
                begin
                    mode_next = csv_fe_pkg::MODE_IDLE;
                end
                else
                begin
                    emit = printable;
                end
            end
            csv_fe_pkg::MODE_TAKE_Q:
            begin
                if (ender || at_limit)
                begin
                    mode_next = csv_fe_pkg::MODE_IDLE;
                end
                else if (is_quote)
                begin
                    mode_next = csv_fe_pkg::MODE_TAKE_QQ;
                end
                else
                begin
                    emit = printable;
                end
            end
            csv_fe_pkg::MODE_TAKE_QQ:
            begin
                // doubled quote below the limit gives one quote, anything else closes
                if (is_quote && !at_limit)
                begin
                    emit      = 1'b1;
                    mode_next = csv_fe_pkg::MODE_TAKE_Q;
                end
                else
                begin
                    mode_next = csv_fe_pkg::MODE_IDLE;
                end
            end
            csv_fe_pkg::MODE_IDLE:
            begin
                mode_next = csv_fe_pkg::MODE_IDLE;
            end
            default:
            begin
                mode_next = csv_fe_pkg::MODE_IDLE;
            end
        endcase
    end

    assign len_next  = emit ? len_cur + 1'b1 : len_cur;
    assign open_next = !s1_item.line_last;

    assign has_result         = emit || s1_item.line_last;
    assign result.field_byte  = emit ? b : 8'h00;
    assign result.byte_valid  = emit;
    assign result.line_done   = s1_item.line_last;
    assign result.field_found = s1_item.line_last && tgt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            mode_reg <= csv_fe_pkg::MODE_START;
            cnt_reg  <= '0;
            len_reg  <= '0;
            tgt_reg  <= 1'b0;
        end
        else if (advance)
        begin
            open_reg <= open_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
            tgt_reg  <= tgt_next;
        end
    end

endmodule

### sv/csv_fe_out_reg.sv
module csv_fe_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  csv_fe_pkg::out_item_t result,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_stall,
    output csv_fe_pkg::out_item_t out_item
);

    logic                  valid_reg;
    logic                  valid_next;
    csv_fe_pkg::out_item_t item_reg;

    // Held while the receiver stalls
    assign busy       = valid_reg && out_stall;
    assign valid_next = load || busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### sv/csv_field_extractor.sv
// CSV field extractor: picks one field out of a CSV line streamed a byte per item.
//
// Input channel (in_valid / in_stall / in_item): one line byte per item, with
// line_last set on the final byte. Output channel (out_valid / out_stall /
// out_item): one item per emitted field byte, plus the item for the last
// byte of the line, which carries line_done and field_found. Bytes that
// give no output (skipped fields, separators, control bytes) vanish.
// Config port (cfg_valid / cfg_ready / cfg_index / cfg_data): register 0 is
// field_index, register 1 is max_len; other indexes are ignored. Always
// ready; write only while no line is in flight.
//
// Path: an accepted item passes the input register, then the parser's
// combinational step into the result register.
// Throughput: 1 item per cycle, unless a result waits in a stalled output register.
// Reset: field_index 0, max_len 511, parser at the start of a line, both
// pipeline registers empty.
// Stall: a waiting result holds in the output register; the input register
// keeps taking items until it holds one that would also give a result, then
// in_stall rises. Items that give no result never stall.
module csv_field_extractor #(
    parameter int FIELD_BUF_BYTES = csv_fe_pkg::FIELD_BUF_BYTES_DEF,
    parameter int MAX_FIELDS      = csv_fe_pkg::MAX_FIELDS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  csv_fe_pkg::in_item_t                  in_item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output csv_fe_pkg::out_item_t                 out_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [csv_fe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csv_fe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    csv_fe_pkg::cfg_t      cfg_reg;
    logic                  s1_valid;
    csv_fe_pkg::in_item_t  s1_item;
    logic                  advance;
    logic                  has_result;
    csv_fe_pkg::out_item_t result;
    logic                  out_busy;

    // Config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_index <= '0;
            cfg_reg.max_len     <= csv_fe_pkg::MAX_LEN_W'(csv_fe_pkg::MAX_LEN_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                csv_fe_pkg::CFG_FIELD_INDEX:
                begin
                    cfg_reg.field_index <= cfg_data[csv_fe_pkg::FIELD_INDEX_W-1:0];
                end
                csv_fe_pkg::CFG_MAX_LEN:
                begin
                    cfg_reg.max_len <= cfg_data[csv_fe_pkg::MAX_LEN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The held item moves on unless it has a result and the output is blocked
    assign advance = s1_valid && (!has_result || !out_busy);

    csv_fe_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    csv_fe_parser #(
        .FIELD_BUF_BYTES (FIELD_BUF_BYTES),
        .MAX_FIELDS      (MAX_FIELDS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s1_item    (s1_item),
        .advance    (advance),
        .has_result (has_result),
        .result     (result)
    );

    csv_fe_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .result    (result),
        .busy      (out_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import csv_fe_pkg::*;

    // Generous bound: every item sent, plus hold-off and drains
    localparam int CYCLE_LIMIT = 50000;
    // Two pipeline stages, plus margin for items that give no result
    localparam int DRAIN_CYCLES = 6;
    localparam logic [8:0] BUF_CAP = 9'(FIELD_BUF_BYTES_DEF - 1);

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Register copies as last written
    logic [FIELD_INDEX_W-1:0] reg_field_index;
    logic [MAX_LEN_W-1:0] reg_max_len;

    // Parser state of the predictor
    mode_t parse_st;
    logic [4:0] fields_seen;
    logic [8:0] bytes_taken;
    bit target_hit;
    bit in_line;
    bit emit_valid;
    logic [7:0] emit_byte;

    out_item_t expected_extracts[$];
    logic [7:0] line_buf[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int hold_off_cycles = 0;
    int burst_left = 0;
    bit steady_send = 1'b0;

    csv_field_extractor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timed out after %0d cycles", $time, cycle_count);
        $display("** csv_field_extractor: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit is_line_end(input logic [7:0] b);
        return b == CH_NUL || b == CH_LF || b == CH_CR;
    endfunction

    // Effective length limit: register, capped by the field buffer
    function automatic logic [8:0] take_limit();
        return (reg_max_len < BUF_CAP) ? reg_max_len : BUF_CAP;
    endfunction

    // Field counter saturates at the last field the block can number
    function automatic void count_field();
        if (fields_seen < MAX_FIELDS_DEF - 1)
            fields_seen++;
    endfunction

    // Control bytes are dropped and do not count towards the limit
    function automatic void keep_byte(input logic [7:0] b);
        if (b >= CH_SPACE)
        begin
            emit_valid = 1'b1;
            emit_byte = b;
            bytes_taken++;
        end
    endfunction

    function automatic void skip_plain_byte(input logic [7:0] b);
        if (b == CH_COMMA)
        begin
            count_field();
            parse_st = MODE_START;
        end
        else if (is_line_end(b))
            parse_st = MODE_IDLE;
    endfunction

    function automatic void take_plain_byte(input logic [7:0] b);
        if (is_line_end(b) || b == CH_COMMA || bytes_taken >= take_limit())
            parse_st = MODE_IDLE;
        else
            keep_byte(b);
    endfunction

    // First byte of a field: decides take or skip, quoted or plain
    function automatic void open_field(input logic [7:0] b);
        if (is_line_end(b))
            parse_st = MODE_IDLE;
        else if (fields_seen == reg_field_index)
        begin
            target_hit = 1'b1;
            if (b == CH_QUOTE)
                parse_st = MODE_TAKE_Q;
            else
            begin
                parse_st = MODE_TAKE_P;
                take_plain_byte(b);
            end
        end
        else if (b == CH_QUOTE)
            parse_st = MODE_SKIP_Q;
        else
        begin
            parse_st = MODE_SKIP_P;
            skip_plain_byte(b);
        end
    endfunction

    function automatic void restart_line();
        parse_st = MODE_START;
        fields_seen = '0;
        bytes_taken = '0;
        target_hit = (reg_field_index == 0);
    endfunction

    // One line byte in, returns 1 with the result item when one is due
    function automatic bit predict_extract(input in_item_t it, output out_item_t res);
        logic [7:0] b;
        b = it.line_byte;
        if (!in_line)
        begin
            restart_line();
            in_line = 1'b1;
        end
        emit_valid = 1'b0;
        emit_byte = '0;
        case (parse_st)
            MODE_START:
                open_field(b);
            MODE_SKIP_P:
                skip_plain_byte(b);
            MODE_SKIP_Q:
            begin
                // CR and LF belong to a skipped quoted field, only NUL ends the line
                if (b == CH_QUOTE)
                    parse_st = MODE_SKIP_QQ;
                else if (b == CH_NUL)
                    parse_st = MODE_IDLE;
            end
            MODE_SKIP_QQ:
            begin
                if (b == CH_QUOTE)
                    parse_st = MODE_SKIP_Q;
                else if (b == CH_COMMA)
                begin
                    count_field();
                    parse_st = MODE_START;
                end
                else if (is_line_end(b))
                    parse_st = MODE_IDLE;
                else
                begin
                    // stray byte after the closing quote opens the next field
                    count_field();
                    open_field(b);
                end
            end
            MODE_TAKE_P:
                take_plain_byte(b);
            MODE_TAKE_Q:
            begin
                if (is_line_end(b) || bytes_taken >= take_limit())
                    parse_st = MODE_IDLE;
                else if (b == CH_QUOTE)
                    parse_st = MODE_TAKE_QQ;
                else
                    keep_byte(b);
            end
            MODE_TAKE_QQ:
            begin
                if (b == CH_QUOTE && bytes_taken < take_limit())
                begin
                    keep_byte(CH_QUOTE);
                    parse_st = MODE_TAKE_Q;
                end
                else
                    parse_st = MODE_IDLE;
            end
            default:
                ;
        endcase
        res.field_byte = emit_byte;
        res.byte_valid = emit_valid;
        res.line_done = it.line_last;
        res.field_found = it.line_last && target_hit;
        if (it.line_last)
        begin
            in_line = 1'b0;
            restart_line();
        end
        return emit_valid || it.line_last;
    endfunction

    // ------------------------------------------------------------------
    // Line content
    // ------------------------------------------------------------------

    function automatic logic [7:0] line_end_byte();
        case ($urandom_range(0, 2))
            0: return CH_NUL;
            1: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Mostly clean text; noise_pct percent of bytes are separators, quotes, controls or any byte
    function automatic logic [7:0] field_text_byte(input int noise_pct);
        logic [7:0] v;
        if ($urandom_range(0, 99) >= noise_pct)
        begin
            v = 8'($urandom_range(8'h20, 8'hFF));
            while (v == CH_COMMA || v == CH_QUOTE)
                v = 8'($urandom_range(8'h20, 8'hFF));
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: v = CH_COMMA;
                1: v = CH_QUOTE;
                2: v = 8'($urandom_range(8'h01, 8'h1F));
                3: v = line_end_byte();
                default: v = 8'($urandom_range(0, 255));
            endcase
        end
        return v;
    endfunction

    // Line of nfields fields with random content, some quoted, with occasional junk
    task automatic build_line(input int nfields, input bit short_fields);
        int f;
        int i;
        int flen;
        logic [7:0] b;
        line_buf.delete();
        for (f = 0; f < nfields; f++)
        begin
            if (f > 0)
                line_buf.push_back(CH_COMMA);
            flen = short_fields ? $urandom_range(0, 2) : $urandom_range(0, 8);
            case ($urandom_range(0, 5))
                0:
                    ;
                1, 2:
                begin
                    line_buf.push_back(CH_QUOTE);
                    for (i = 0; i < flen; i++)
                    begin
                        b = ($urandom_range(0, 4) == 0) ? CH_QUOTE : field_text_byte(6);
                        line_buf.push_back(b);
                        if (b == CH_QUOTE)
                            line_buf.push_back(CH_QUOTE);
                    end
                    line_buf.push_back(CH_QUOTE);
                    // junk straight after the closing quote
                    if ($urandom_range(0, 4) == 0)
                        line_buf.push_back(field_text_byte(10));
                end
                default:
                begin
                    for (i = 0; i < flen; i++)
                        line_buf.push_back(field_text_byte(4));
                end
            endcase
        end
        // early line end with trailing bytes that must be ignored
        if ($urandom_range(0, 5) == 0)
        begin
            line_buf.push_back(line_end_byte());
            repeat ($urandom_range(0, 3))
                line_buf.push_back(field_text_byte(30));
        end
        if (line_buf.size() == 0)
            line_buf.push_back(field_text_byte(50));
    endtask

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Called just after a rising edge; returns at the edge that took the item, or after a pause unless steady_send
    task automatic send_line_byte(input in_item_t it);
        out_item_t res;
        in_valid <= 1'b1;
        in_item <= it;
        @(negedge clk);
        while (in_stall !== 1'b0)
            @(negedge clk);
        if (predict_extract(it, res))
            expected_extracts.push_back(res);
        @(posedge clk);
        if (!steady_send)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ?
                    $urandom_range(30, 80) : $urandom_range(0, 12);
            end
        end
    endtask

    task automatic send_line();
        in_item_t it;
        int i;
        for (i = 0; i < line_buf.size(); i++)
        begin
            it.line_byte = line_buf[i];
            it.line_last = (i == line_buf.size() - 1);
            send_line_byte(it);
        end
    endtask

    // Writes both registers back to back, valid held high between them
    task automatic set_config(input logic [FIELD_INDEX_W-1:0] fi,
                              input logic [MAX_LEN_W-1:0] ml);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FIELD_INDEX;
        cfg_data <= {{(CFG_DATA_W-FIELD_INDEX_W){1'b0}}, fi};
        @(negedge clk);
        while (cfg_ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        reg_field_index = fi;
        cfg_index <= CFG_MAX_LEN;
        cfg_data <= ml;
        @(negedge clk);
        while (cfg_ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        reg_max_len = ml;
        cfg_valid <= 1'b0;
    endtask

    // Wait for every expected item, then let items with no result clear the pipe
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_extracts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : stall_pattern
        int style;
        int span;
        int k;
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else
            begin
                style = $urandom_range(0, 3);
                span = $urandom_range(8, 60);
                for (k = 0; k < span && hold_off_cycles == 0; k++)
                begin
                    case (style)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 99) < 30);
                        2: out_stall <= (k % 4 == 3);
                        default: out_stall <= ($urandom_range(0, 99) < 70);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Sampled at the falling edge: the item is taken at the next rising edge
    initial
    begin : result_check
        out_item_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_extracts.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_extracts.pop_front();
                    if (out_item.field_byte !== want.field_byte)
                    begin
                        $display("%0t: field_byte expected %h actual %h",
                                 $time, want.field_byte, out_item.field_byte);
                        mismatch_count++;
                    end
                    if (out_item.byte_valid !== want.byte_valid)
                    begin
                        $display("%0t: byte_valid expected %b actual %b",
                                 $time, want.byte_valid, out_item.byte_valid);
                        mismatch_count++;
                    end
                    if (out_item.line_done !== want.line_done)
                    begin
                        $display("%0t: line_done expected %b actual %b",
                                 $time, want.line_done, out_item.line_done);
                        mismatch_count++;
                    end
                    if (out_item.field_found !== want.field_found)
                    begin
                        $display("%0t: field_found expected %b actual %b",
                                 $time, want.field_found, out_item.field_found);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built lines: quoting, controls, byte extremes, line enders, empty end field
    task automatic test_directed_cases();
        set_config(5'd0, 9'd511);
        // "a""b" then junk: doubled quote gives one quote, closing quote ends the take
        line_buf = '{CH_QUOTE, 8'h61, CH_QUOTE, CH_QUOTE, 8'h62, CH_QUOTE, 8'h78};
        send_line();
        // control byte dropped, 0xFF and 0x7F kept, comma ends the field
        line_buf = '{8'h01, 8'hFF, 8'h7F, CH_COMMA, 8'h7A};
        send_line();
        // a lone NUL: field 0 still counts as found
        line_buf = '{CH_NUL};
        send_line();
        drain_results();
        set_config(5'd2, 9'd511);
        // LF inside a skipped quoted field, stray byte after its closing quote
        line_buf = '{CH_QUOTE, CH_LF, CH_QUOTE, 8'h79, CH_COMMA, 8'h71};
        send_line();
        // CR ends the line before field 2
        line_buf = '{8'h61, CH_CR, 8'h62, CH_COMMA};
        send_line();
        drain_results();
        // field that would start at the end of the line is not found
        set_config(5'd1, 9'd511);
        line_buf = '{8'h61, CH_COMMA};
        send_line();
        drain_results();
    endtask

    task automatic test_length_limit();
        int i;
        // longest field the limit allows, and a few bytes past it
        set_config(5'd0, 9'd255);
        line_buf.delete();
        for (i = 0; i < 260; i++)
            line_buf.push_back(field_text_byte(0));
        send_line();
        drain_results();
        // limit reached on a doubled quote inside a quoted field
        set_config(5'd0, 9'd1);
        line_buf = '{CH_QUOTE, 8'h61, CH_QUOTE, CH_QUOTE, CH_QUOTE, 8'h62};
        send_line();
        drain_results();
    endtask

    // Receiver holds off while every item gives a result: the block fills and stalls
    task automatic test_output_backpressure();
        int i;
        set_config(5'd0, 9'd511);
        steady_send = 1'b1;
        hold_off_cycles = 300;
        line_buf.delete();
        for (i = 0; i < 48; i++)
            line_buf.push_back(field_text_byte(0));
        send_line();
        drain_results();
        steady_send = 1'b0;
    endtask

    task automatic test_random_lines();
        int phase;
        int sent;
        int nf;
        int i;
        logic [4:0] fi;
        logic [8:0] ml;
        for (phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:
                begin
                    fi = 5'd31;
                    ml = 9'd0;
                end
                1:
                begin
                    fi = 5'd0;
                    ml = 9'd511;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: fi = 5'd0;
                        1: fi = 5'd31;
                        2: fi = 5'($urandom_range(1, 3));
                        default: fi = 5'($urandom_range(0, 31));
                    endcase
                    case ($urandom_range(0, 3))
                        0: ml = 9'd0;
                        1: ml = 9'd511;
                        2: ml = 9'($urandom_range(1, 6));
                        default: ml = 9'($urandom_range(0, 511));
                    endcase
                end
            endcase
            set_config(fi, ml);
            steady_send = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < 20)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    // raw noise line, any byte value
                    line_buf.delete();
                    repeat ($urandom_range(1, 10))
                        line_buf.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    // fields past the last one exercise the saturating counter
                    if (fi == 5'd31 && $urandom_range(0, 1) == 1)
                        nf = 34;
                    else
                        nf = fi + $urandom_range(0, 2);
                    if (nf == 0)
                        nf = 1;
                    build_line(nf, fi > 6);
                end
                send_line();
                sent += line_buf.size();
            end
            drain_results();
            steady_send = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        reg_field_index = '0;
        reg_max_len = MAX_LEN_W'(MAX_LEN_RESET);
        in_line = 1'b0;
        restart_line();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_length_limit();
        test_output_backpressure();
        test_random_lines();

        drain_results();
        if (mismatch_count == 0)
            $display("** csv_field_extractor: PASSED **");
        else
            $display("** csv_field_extractor: FAILED **");
        $finish;
    end

endmodule
